### sv/sorted_abs_diff_sums_assert.svh
// assertion macros for the sorted absolute difference sum block
`ifndef SORTED_ABS_DIFF_SUMS_ASSERT_SVH
`define SORTED_ABS_DIFF_SUMS_ASSERT_SVH

`ifndef NO_ASSERTIONS

// same-cycle implication, checked out of reset
`define SADS_ASSERT_NOW(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error("sorted_abs_diff_sums: assertion failed");

// next-cycle implication, checked out of reset
`define SADS_ASSERT_NEXT(lbl, ante, cons) \
  lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error("sorted_abs_diff_sums: assertion failed");

`else

`define SADS_ASSERT_NOW(lbl, ante, cons)
`define SADS_ASSERT_NEXT(lbl, ante, cons)

`endif

`endif

### sv/sads_pkg.sv
// shared types and constants for the sorted absolute difference sum block
package sads_pkg;

  localparam int VALUE_W          = 16;
  localparam int DIFF_W           = 22;
  localparam int POS_W            = 6;
  localparam int COUNT_W          = 7;
  localparam int MAX_ELEMENTS_DEF = 64;

  // coefficient 2*i + 2 - n lies in -62..64
  localparam int COEF_W = 8;
  localparam int PROD_W = VALUE_W + 1 + COEF_W;
  localparam int SUM_W  = PROD_W + 3;

  localparam logic [DIFF_W-1:0] DIFF_MAX = {DIFF_W{1'b1}};

  typedef struct packed {
    logic [VALUE_W-1:0] value;
    logic               last_element;
  } item_t;

  typedef struct packed {
    logic [DIFF_W-1:0] diff_sum;
    logic [POS_W-1:0]  position;
    logic              last_result;
    logic              order_error;
    logic              overflow;
  } result_t;

  // per-set state handed from the loader to the walk
  typedef struct packed {
    logic [COUNT_W-1:0] count;
    logic [DIFF_W-1:0]  total;
    logic               order_err;
    logic               overflow;
  } set_info_t;

endpackage

### sv/sads_store.sv
// element store: one write port, one registered read port with enable
module sads_store #(
  parameter int DEPTH = sads_pkg::MAX_ELEMENTS_DEF,
  parameter int WIDTH = sads_pkg::VALUE_W
) (
  input  logic                     clk,
  input  logic                     wr_en,
  input  logic [$clog2(DEPTH)-1:0] wr_addr,
  input  logic [WIDTH-1:0]         wr_data,
  input  logic                     rd_en,
  input  logic [$clog2(DEPTH)-1:0] rd_addr,
  output logic [WIDTH-1:0]         rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
  end

  // read port, data held while not enabled
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### sv/sads_walk.sv
// result walk: reads the store in order and turns prefix sums into results
module sads_walk #(
  parameter int MAX_ELEMENTS = sads_pkg::MAX_ELEMENTS_DEF
) (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  sads_pkg::set_info_t             info,
  output logic                            rd_en,
  output logic [$clog2(MAX_ELEMENTS)-1:0] rd_addr,
  input  logic [sads_pkg::VALUE_W-1:0]    rd_data,
  output logic                            result_valid,
  input  logic                            result_stall,
  output sads_pkg::result_t               result,
  output logic                            done
);
  import sads_pkg::*;

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic                     walk_run;
  logic [AW-1:0]            walk_idx;
  logic                     s1_valid;
  logic [AW-1:0]            s1_idx;
  logic                     s1_last;
  logic [DIFF_W-1:0]        prefix;
  logic                     s2_valid;
  logic [AW-1:0]            s2_idx;
  logic                     s2_last;
  logic signed [PROD_W-1:0] s2_prod;
  logic [DIFF_W-1:0]        s2_prefix;

  logic                     adv;
  logic                     issue_last;
  logic [DIFF_W-1:0]        prefix_next;
  logic signed [COEF_W-1:0] coef;
  logic signed [PROD_W-1:0] prod_c;
  logic signed [SUM_W-1:0]  sum_c;
  logic [DIFF_W-1:0]        diff_c;

  // whole pipeline moves when the output register is free or being taken
  assign adv        = !result_valid || !result_stall;
  assign rd_en      = adv && walk_run;
  assign rd_addr    = walk_idx;
  assign issue_last = (COUNT_W'(walk_idx) == info.count - COUNT_W'(1));

  // stage one: prefix update and coefficient product
  assign prefix_next = prefix + DIFF_W'(rd_data);
  assign coef   = $signed(COEF_W'({s1_idx, 1'b0})) + COEF_W'(2)
                - $signed(COEF_W'(info.count));
  assign prod_c = $signed({1'b0, rd_data}) * coef;

  // stage two: add total minus twice the prefix, then clamp
  assign sum_c = $signed({{(SUM_W-PROD_W){s2_prod[PROD_W-1]}}, s2_prod})
               + $signed({{(SUM_W-DIFF_W){1'b0}}, info.total})
               - $signed({{(SUM_W-DIFF_W-1){1'b0}}, s2_prefix, 1'b0});

  always_comb begin
    if (sum_c[SUM_W-1]) begin
      diff_c = '0;
    end else if (|sum_c[SUM_W-2:DIFF_W]) begin
      diff_c = DIFF_MAX;
    end else begin
      diff_c = sum_c[DIFF_W-1:0];
    end
  end

  assign done = adv && s2_valid && s2_last;

  // address issue
  always_ff @(posedge clk) begin
    if (rst) begin
      walk_run <= 1'b0;
      walk_idx <= '0;
    end else if (start) begin
      walk_run <= 1'b1;
      walk_idx <= '0;
    end else if (adv && walk_run) begin
      if (issue_last) begin
        walk_run <= 1'b0;
      end else begin
        walk_idx <= walk_idx + AW'(1);
      end
    end
  end

  // pipeline valids and output valid
  always_ff @(posedge clk) begin
    if (rst) begin
      s1_valid     <= 1'b0;
      s2_valid     <= 1'b0;
      result_valid <= 1'b0;
    end else if (adv) begin
      s1_valid     <= walk_run;
      s2_valid     <= s1_valid;
      result_valid <= s2_valid;
    end
  end

  // running prefix, cleared at the start of each walk
  always_ff @(posedge clk) begin
    if (rst || start) begin
      prefix <= '0;
    end else if (adv && s1_valid) begin
      prefix <= prefix_next;
    end
  end

  // stage payloads
  always_ff @(posedge clk) begin
    if (adv) begin
      if (walk_run) begin
        s1_idx  <= walk_idx;
        s1_last <= issue_last;
      end
      if (s1_valid) begin
        s2_idx    <= s1_idx;
        s2_last   <= s1_last;
        s2_prod   <= prod_c;
        s2_prefix <= prefix_next;
      end
      if (s2_valid) begin
        result.diff_sum    <= diff_c;
        result.position    <= POS_W'(s2_idx);
        result.last_result <= s2_last;
        result.order_error <= info.order_err;
        result.overflow    <= info.overflow;
      end
    end
  end

endmodule

### sv/sorted_abs_diff_sums.sv
// Sorted absolute difference sums, top level.
// The item channel (item_valid / item_stall / item) loads one value per
// cycle while item_stall is low into the element store and adds it to the
// running total. The transaction whose last_element bit is set starts a
// walk over the store. The result channel (result_valid / result_stall /
// result) then gives one transaction per stored element, in index order, each
// with the sum of absolute differences to all other elements of the set.
// Each result passes the store read, stage two and output registers; after
// the first, results come one per cycle (set by the single store read port)
// while result_stall is low. item_stall is high from the last item until
// the final result enters the output register. A result_stall while a
// result is valid freezes the whole walk pipeline and the store read; the
// output holds until taken. Items past the store size are dropped and set
// the overflow bit; a value below its predecessor sets order_error. After
// the walk the count, total and flags clear for the next set. Reset (rst,
// synchronous) empties the set and the pipeline; store contents are left
// as they are and only entries of the current set are read.
module sorted_abs_diff_sums #(
  parameter int MAX_ELEMENTS = sads_pkg::MAX_ELEMENTS_DEF
) (
  input  logic              clk,
  input  logic              rst,
  input  logic              item_valid,
  output logic              item_stall,
  input  sads_pkg::item_t   item,
  output logic              result_valid,
  input  logic              result_stall,
  output sads_pkg::result_t result
);
  import sads_pkg::*;

  `include "sorted_abs_diff_sums_assert.svh"

  localparam int AW = $clog2(MAX_ELEMENTS);

  logic               busy;
  logic [COUNT_W-1:0] count;
  logic [DIFF_W-1:0]  total;
  logic [VALUE_W-1:0] prev_value;
  logic               order_flag;
  logic               overflow_flag;

  logic               accept;
  logic               full;
  logic               walk_start;
  logic               walk_done;
  logic               rd_en;
  logic [AW-1:0]      rd_addr;
  logic [VALUE_W-1:0] rd_data;
  set_info_t          info;

  assign item_stall = busy;
  assign accept     = item_valid && !item_stall;
  assign full       = (count == COUNT_W'(MAX_ELEMENTS));
  assign walk_start = accept && item.last_element;

  assign info.count     = count;
  assign info.total     = total;
  assign info.order_err = order_flag;
  assign info.overflow  = overflow_flag;

  // set loader and walk control
  always_ff @(posedge clk) begin
    if (rst || walk_done) begin
      busy          <= 1'b0;
      count         <= '0;
      total         <= '0;
      prev_value    <= '0;
      order_flag    <= 1'b0;
      overflow_flag <= 1'b0;
    end else if (accept) begin
      prev_value <= item.value;
      if (count != '0 && item.value < prev_value) begin
        order_flag <= 1'b1;
      end
      if (full) begin
        overflow_flag <= 1'b1;
      end else begin
        count <= count + COUNT_W'(1);
        total <= total + DIFF_W'(item.value);
      end
      if (item.last_element) begin
        busy <= 1'b1;
      end
    end
  end

  sads_store #(
    .DEPTH (MAX_ELEMENTS),
    .WIDTH (VALUE_W)
  ) u_store (
    .clk     (clk),
    .wr_en   (accept && !full),
    .wr_addr (count[AW-1:0]),
    .wr_data (item.value),
    .rd_en   (rd_en),
    .rd_addr (rd_addr),
    .rd_data (rd_data)
  );

  sads_walk #(
    .MAX_ELEMENTS (MAX_ELEMENTS)
  ) u_walk (
    .clk          (clk),
    .rst          (rst),
    .start        (walk_start),
    .info         (info),
    .rd_en        (rd_en),
    .rd_addr      (rd_addr),
    .rd_data      (rd_data),
    .result_valid (result_valid),
    .result_stall (result_stall),
    .result       (result),
    .done         (walk_done)
  );

  // a walk always covers at least one stored element
  `SADS_ASSERT_NOW(a_busy_has_elements, busy, count != '0)
  // overflow can only be flagged once the store is full
  `SADS_ASSERT_NOW(a_overflow_when_full, overflow_flag, full)
  // the final item of a set closes the input until the walk ends
  `SADS_ASSERT_NEXT(a_last_blocks_input, walk_start, item_stall)

endmodule
